FILE: rtl/vsrt_pkg.sv
package vsrt_pkg;

    // Width of the exact intermediate coordinates (bounded below 2^44 in magnitude).
    localparam int V_W = 48;

    localparam int COORD_W = 32;
    localparam int SCALE_W = 24;
    localparam int TRIG_W  = 16;

    typedef logic signed [V_W-1:0] wide_t;

    typedef enum logic [2:0] {
        REG_AXIS_X = 3'd0,
        REG_AXIS_Y = 3'd1,
        REG_AXIS_Z = 3'd2,
        REG_ROT_X  = 3'd3,
        REG_ROT_Y  = 3'd4,
        REG_ROT_Z  = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic                       mode;
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
        logic signed [COORD_W-1:0]  z;
    } in_t;

    typedef struct packed {
        logic  mode;
        wide_t x;
        wide_t y;
        wide_t z;
    } vec_t;

    // Plane rotation view: a and b rotate, p passes.
    typedef struct packed {
        logic  mode;
        wide_t a;
        wide_t b;
        wide_t p;
    } rvec_t;

    typedef struct packed {
        logic signed [TRIG_W-1:0] cos_v;
        logic signed [TRIG_W-1:0] sin_v;
    } trig_t;

    typedef struct packed {
        logic                ovf;
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [COORD_W-1:0]  z;
    } res_t;

endpackage

FILE: rtl/vsrt_scale_cell.sv
module vsrt_scale_cell
    import vsrt_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  in_t                       in_data,
    input  logic signed [SCALE_W-1:0] scale_x,
    input  logic signed [SCALE_W-1:0] scale_y,
    input  logic signed [SCALE_W-1:0] scale_z,
    output logic                      out_valid,
    input  logic                      out_ready,
    output vec_t                      out_data
);

    localparam int P_W = COORD_W + SCALE_W;

    logic valid_reg;
    vec_t data_reg;
    vec_t data_next;

    function automatic wide_t scale_round(logic signed [COORD_W-1:0] c,
                                          logic signed [SCALE_W-1:0] s);
        logic signed [P_W-1:0] prod;
        logic signed [P_W:0]   sum;
        logic signed [P_W:0]   sh;
        prod = c * s;
        sum  = (P_W+1)'(prod) + (P_W+1)'(signed'(32'sd32768));
        sh   = sum >>> 16;
        return wide_t'(sh[V_W-1:0]);
    endfunction

    always_comb
    begin
        data_next.mode = in_data.mode;
        data_next.x    = scale_round(in_data.x, scale_x);
        data_next.y    = scale_round(in_data.y, scale_y);
        data_next.z    = scale_round(in_data.z, scale_z);
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

FILE: rtl/vsrt_rot_cell.sv
module vsrt_rot_cell
    import vsrt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  rvec_t in_data,
    input  trig_t trig,
    output logic  out_valid,
    input  logic  out_ready,
    output rvec_t out_data
);

    localparam int M_W = TRIG_W + V_W;
    localparam int S_W = M_W + 2;

    logic  valid_reg;
    rvec_t data_reg;
    rvec_t data_next;

    logic signed [M_W-1:0] ca, sb, sa, cb;
    logic signed [S_W-1:0] na_sum, nb_sum, na_sh, nb_sh;

    // Exact sum of two products, rounded half up once to Q.16.
    always_comb
    begin
        ca     = trig.cos_v * in_data.a;
        sb     = trig.sin_v * in_data.b;
        sa     = trig.sin_v * in_data.a;
        cb     = trig.cos_v * in_data.b;
        na_sum = S_W'(ca) - S_W'(sb) + S_W'(signed'(16'sd8192));
        nb_sum = S_W'(sa) + S_W'(cb) + S_W'(signed'(16'sd8192));
        na_sh  = na_sum >>> 14;
        nb_sh  = nb_sum >>> 14;
        data_next.mode = in_data.mode;
        data_next.a    = wide_t'(na_sh[V_W-1:0]);
        data_next.b    = wide_t'(nb_sh[V_W-1:0]);
        data_next.p    = in_data.p;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

FILE: rtl/vsrt_out_cell.sv
module vsrt_out_cell
    import vsrt_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  vec_t                      in_data,
    input  logic signed [COORD_W-1:0] ofs_x,
    input  logic signed [COORD_W-1:0] ofs_y,
    input  logic signed [COORD_W-1:0] ofs_z,
    output logic                      out_valid,
    input  logic                      out_ready,
    output res_t                      out_data
);

    logic valid_reg;
    res_t data_reg;
    res_t data_next;

    logic [2:0] sat;

    function automatic wide_t add_ofs(wide_t v, logic signed [COORD_W-1:0] o, logic pt);
        wide_t o_w;
        o_w = pt ? wide_t'({{(V_W-COORD_W){o[COORD_W-1]}}, o}) : '0;
        return v + o_w;
    endfunction

    // Clamp to signed 32 bits; flag when the upper bits are not a sign run.
    function automatic logic [COORD_W:0] clamp(wide_t v);
        logic [V_W-COORD_W:0] hi;
        hi = v[V_W-1:COORD_W-1];
        if (hi == '0 || hi == '1)
        begin
            return {1'b0, v[COORD_W-1:0]};
        end
        else if (v[V_W-1])
        begin
            return {1'b1, 1'b1, {(COORD_W-1){1'b0}}};
        end
        else
        begin
            return {1'b1, 1'b0, {(COORD_W-1){1'b1}}};
        end
    endfunction

    always_comb
    begin
        logic [COORD_W:0] cx, cy, cz;
        cx = clamp(add_ofs(in_data.x, ofs_x, !in_data.mode));
        cy = clamp(add_ofs(in_data.y, ofs_y, !in_data.mode));
        cz = clamp(add_ofs(in_data.z, ofs_z, !in_data.mode));
        sat = {cz[COORD_W], cy[COORD_W], cx[COORD_W]};
        data_next.ovf = |sat;
        data_next.x   = cx[COORD_W-1:0];
        data_next.y   = cy[COORD_W-1:0];
        data_next.z   = cz[COORD_W-1:0];
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

FILE: rtl/vertex_scale_rotate_translate.sv
// Channel   | Dir | Signals                          | Beat
// ----------+-----+----------------------------------+------------------------------------
// s_axis    | in  | tvalid tready tdata[95:0] tuser  | one vertex: x,y,z Q16.16, mode
// m_axis    | out | tvalid tready tdata[95:0] tuser  | one result: x,y,z Q16.16, overflow
// cfg       | in  | cfg_we cfg_index[2:0] cfg_data   | one register write, no wait
//
// One vertex per cycle sustained while m_axis_tready is high; stages are scale, rotate X, Y, Z, offset/clamp.
// Each cell holds one beat and takes a new one when empty or when its neighbor takes its beat,
// so bubbles close up behind a stalled output while m_axis_tready is low.
// Every cell takes one beat per cycle unless its output stalls; each rotation cell forms four 16x48 products per cycle.
// rst_n (async, active low) empties the chain and loads unit scale, zero offset, cos 1, sin 0.
// Config writes are ignored for indexes above five.
module vertex_scale_rotate_translate
    import vsrt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // [31:0] in_x, [63:32] in_y, [95:64] in_z
    input  logic        s_axis_tuser,   // [0] mode

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // [31:0] out_x, [63:32] out_y, [95:64] out_z
    output logic        m_axis_tuser,   // [0] overflow

    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [55:0] cfg_data
);

    // Configuration registers
    logic [2:0][55:0] axis_reg;
    logic [2:0][31:0] rot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                axis_reg[i] <= 56'h01_0000_0000_0000;
                rot_reg[i]  <= 32'h4000_0000;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_AXIS_X: axis_reg[0] <= cfg_data;
                REG_AXIS_Y: axis_reg[1] <= cfg_data;
                REG_AXIS_Z: axis_reg[2] <= cfg_data;
                REG_ROT_X:  rot_reg[0]  <= cfg_data[31:0];
                REG_ROT_Y:  rot_reg[1]  <= cfg_data[31:0];
                REG_ROT_Z:  rot_reg[2]  <= cfg_data[31:0];
                default:    ;
            endcase
        end
    end

    // Cell chain
    in_t   in_beat;
    vec_t  sc_data, rz_vec;
    rvec_t rx_in, rx_out, ry_in, ry_out, rz_in, rz_out;
    res_t  res;

    logic sc_valid, sc_ready;
    logic rx_valid, rx_ready;
    logic ry_valid, ry_ready;
    logic rz_valid, rz_ready;

    assign in_beat.mode = s_axis_tuser;
    assign in_beat.x    = s_axis_tdata[31:0];
    assign in_beat.y    = s_axis_tdata[63:32];
    assign in_beat.z    = s_axis_tdata[95:64];

    vsrt_scale_cell u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (in_beat),
        .scale_x   (axis_reg[0][55:32]),
        .scale_y   (axis_reg[1][55:32]),
        .scale_z   (axis_reg[2][55:32]),
        .out_valid (sc_valid),
        .out_ready (sc_ready),
        .out_data  (sc_data)
    );

    // About X: (y, z) rotate, x passes
    assign rx_in = '{mode: sc_data.mode, a: sc_data.y, b: sc_data.z, p: sc_data.x};

    vsrt_rot_cell u_rot_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sc_valid),
        .in_ready  (sc_ready),
        .in_data   (rx_in),
        .trig      (trig_t'(rot_reg[0])),
        .out_valid (rx_valid),
        .out_ready (rx_ready),
        .out_data  (rx_out)
    );

    // About Y: (z, x) rotate, y passes. rx_out: a=y b=z p=x
    assign ry_in = '{mode: rx_out.mode, a: rx_out.b, b: rx_out.p, p: rx_out.a};

    vsrt_rot_cell u_rot_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rx_valid),
        .in_ready  (rx_ready),
        .in_data   (ry_in),
        .trig      (trig_t'(rot_reg[1])),
        .out_valid (ry_valid),
        .out_ready (ry_ready),
        .out_data  (ry_out)
    );

    // About Z: (x, y) rotate, z passes. ry_out: a=z b=x p=y
    assign rz_in = '{mode: ry_out.mode, a: ry_out.b, b: ry_out.p, p: ry_out.a};

    vsrt_rot_cell u_rot_z (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ry_valid),
        .in_ready  (ry_ready),
        .in_data   (rz_in),
        .trig      (trig_t'(rot_reg[2])),
        .out_valid (rz_valid),
        .out_ready (rz_ready),
        .out_data  (rz_out)
    );

    // rz_out: a=x b=y p=z
    assign rz_vec = '{mode: rz_out.mode, x: rz_out.a, y: rz_out.b, z: rz_out.p};

    vsrt_out_cell u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rz_valid),
        .in_ready  (rz_ready),
        .in_data   (rz_vec),
        .ofs_x     (axis_reg[0][31:0]),
        .ofs_y     (axis_reg[1][31:0]),
        .ofs_z     (axis_reg[2][31:0]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (res)
    );

    assign m_axis_tdata = {res.z, res.y, res.x};
    assign m_axis_tuser = res.ovf;

`ifndef SYNTHESIS
    // An accepted beat always lands in the scale cell.
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> sc_valid)
        else $error("accepted beat not held in scale cell");

    // Chain full and output stalled: no room for a new beat.
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        sc_valid && rx_valid && ry_valid && rz_valid && m_axis_tvalid && !m_axis_tready
        |-> !s_axis_tready)
        else $error("input accepted with full chain");

    // Overflow flag only with a clamped component.
    a_ovf_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |->
        (m_axis_tdata[31:0] == 32'h7fff_ffff || m_axis_tdata[31:0] == 32'h8000_0000 ||
         m_axis_tdata[63:32] == 32'h7fff_ffff || m_axis_tdata[63:32] == 32'h8000_0000 ||
         m_axis_tdata[95:64] == 32'h7fff_ffff || m_axis_tdata[95:64] == 32'h8000_0000))
        else $error("overflow flagged without clamped component");
`endif

endmodule
